### rtl/core/assert_macros.svh
// assertion macros shared by the remap rtl
// each expands to one labeled concurrent assertion clocked on the given clock
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RMAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMAP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rmap_pkg.sv
// shared types and constants for the controller range remap pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rmap_pkg;

  localparam int VAL_W  = 7;
  localparam int SPAN_W = 8;
  localparam int NUM_CONTROLLERS_DEF = 128;

  localparam logic [VAL_W-1:0] VALUE_MAX = 7'd127;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // remainder is split over two stages: upper value bits, then lower ones
  localparam int REM_HI_TOP   = 6;
  localparam int REM_HI_STEPS = 4;
  localparam int REM_LO_TOP   = 2;
  localparam int REM_LO_STEPS = 3;

  typedef struct packed {
    logic [VAL_W-1:0]  cc;
    logic [VAL_W-1:0]  value;
    logic [VAL_W-1:0]  lo;
    logic [VAL_W-1:0]  hi;
    logic [VAL_W-1:0]  mn;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] rem;
    logic              eq;
    logic              pass;
  } stage_t;

endpackage

`default_nettype wire

### rtl/core/rmap_in_if.sv
// input channel: valid/ready plus one remap or table write transaction
// depends on rmap_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rmap_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [rmap_pkg::VAL_W-1:0] controller_number;
  logic [rmap_pkg::VAL_W-1:0] control_value;
  logic [rmap_pkg::VAL_W-1:0] entry_low;
  logic [rmap_pkg::VAL_W-1:0] entry_high;

  modport source (output valid, opcode, controller_number, control_value, entry_low,
                  entry_high, input ready);
  modport sink   (input valid, opcode, controller_number, control_value, entry_low,
                  entry_high, output ready);
endinterface

`default_nettype wire

### rtl/core/rmap_out_if.sv
// result channel: valid/ready plus one remapped control change
// depends on rmap_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rmap_out_if;
  logic                      valid;
  logic                      ready;
  logic [rmap_pkg::VAL_W-1:0] controller_out;
  logic [rmap_pkg::VAL_W-1:0] remapped_value;

  modport source (output valid, controller_out, remapped_value, input ready);
  modport sink   (input valid, controller_out, remapped_value, output ready);
endinterface

`default_nettype wire

### rtl/core/rmap_lookup.sv
// first stage: bound table memory with per-entry valid bits, registered read
// depends on rmap_pkg and rmap_in_if
`timescale 1ns / 1ps
`default_nettype none

module rmap_lookup #(
  parameter int NUM_CONTROLLERS = rmap_pkg::NUM_CONTROLLERS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  rmap_in_if.sink             in_chan,
  output logic                dn_valid,
  input  wire logic           dn_ready,
  output rmap_pkg::stage_t    dn_data
);

  localparam int IDX_W = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
  localparam logic [rmap_pkg::VAL_W:0] NUM_LIM = (rmap_pkg::VAL_W+1)'(NUM_CONTROLLERS);
  localparam int ENT_W = 2 * rmap_pkg::VAL_W;

  logic [ENT_W-1:0]            bound_mem_r [NUM_CONTROLLERS];
  logic [NUM_CONTROLLERS-1:0]  ent_vld_r;
  logic [ENT_W-1:0]            rd_data_r;
  logic                        rd_vld_r;
  logic                        v_r;
  logic [rmap_pkg::VAL_W-1:0]  cc_r;
  logic [rmap_pkg::VAL_W-1:0]  value_r;
  logic                        pass_r;

  logic                        up_ready;
  logic                        accept;
  logic                        in_range;
  logic [IDX_W-1:0]            idx;

  assign up_ready      = !v_r || dn_ready;
  assign in_chan.ready = up_ready;
  assign accept        = in_chan.valid && up_ready;
  assign in_range      = {1'b0, in_chan.controller_number} < NUM_LIM;
  assign idx           = in_chan.controller_number[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (accept && in_chan.opcode == rmap_pkg::OP_WRITE && in_range) begin
      ent_vld_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_chan.opcode == rmap_pkg::OP_WRITE && in_range) begin
      bound_mem_r[idx] <= {in_chan.entry_low, in_chan.entry_high};
    end
  end

  // a write lands in the table before any later item can read it
  always_ff @(posedge clk) begin
    if (up_ready) begin
      rd_data_r <= bound_mem_r[idx];
      rd_vld_r  <= ent_vld_r[idx];
      cc_r      <= in_chan.controller_number;
      value_r   <= in_chan.control_value;
      pass_r    <= !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= in_chan.valid && in_chan.opcode == rmap_pkg::OP_EVENT;
    end
  end

  // entries never written read as the full range
  always_comb begin
    dn_data       = '0;
    dn_data.cc    = cc_r;
    dn_data.value = value_r;
    dn_data.pass  = pass_r;
    dn_data.lo    = rd_vld_r ? rd_data_r[ENT_W-1:rmap_pkg::VAL_W] : '0;
    dn_data.hi    = rd_vld_r ? rd_data_r[rmap_pkg::VAL_W-1:0] : rmap_pkg::VALUE_MAX;
  end

  assign dn_valid = v_r;

endmodule

`default_nettype wire

### rtl/core/rmap_minmax.sv
// second stage: orders the bounds and forms the span max - min + 1
// depends on rmap_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmap_minmax (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire rmap_pkg::stage_t  up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output rmap_pkg::stage_t       dn_data
);

  logic                        v_r;
  rmap_pkg::stage_t            data_r;
  rmap_pkg::stage_t            data_nxt;
  logic [rmap_pkg::VAL_W-1:0]  mx;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    data_nxt    = up_data;
    data_nxt.eq = up_data.lo == up_data.hi;
    data_nxt.mn = (up_data.lo <= up_data.hi) ? up_data.lo : up_data.hi;
    mx          = (up_data.lo <= up_data.hi) ? up_data.hi : up_data.lo;
    data_nxt.span = {1'b0, mx} - {1'b0, data_nxt.mn} + rmap_pkg::SPAN_W'(1);
    data_nxt.rem  = '0;
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### rtl/core/rmap_remstep.sv
// remainder stage: a few restoring steps of value mod span, msb first
// depends on rmap_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmap_remstep #(
  parameter int TOP_BIT   = rmap_pkg::REM_HI_TOP,
  parameter int NUM_STEPS = rmap_pkg::REM_HI_STEPS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire rmap_pkg::stage_t  up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output rmap_pkg::stage_t       dn_data
);

  logic                          v_r;
  rmap_pkg::stage_t              data_r;
  rmap_pkg::stage_t              data_nxt;

  assign up_ready = !v_r || dn_ready;

  // remainder stays below span, so the shifted value fits in span width
  always_comb begin
    logic [rmap_pkg::SPAN_W-1:0] r;
    r = up_data.rem;
    for (int k = 0; k < NUM_STEPS; k++) begin
      r = {r[rmap_pkg::SPAN_W-2:0], up_data.value[3'(TOP_BIT - k)]};
      if (r >= up_data.span) begin
        r = r - up_data.span;
      end
    end
    data_nxt     = up_data;
    data_nxt.rem = r;
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### rtl/core/midi_controller_range_remap.sv
// MIDI control change range remapper, in_chan consumes one transaction per cycle unless stalled.
// Opcode write stores a low/high bound pair for a controller and gives no result;
// opcode event looks up its controller and returns min + value mod span, or the
// bound itself when both bounds are equal, on out_chan.
// Controllers at or above NUM_CONTROLLERS pass their value through; writes to
// them are dropped.
// Path: an event accepted on in_chan passes the table read, min/max, two remainder
// stages and the output register before it shows up on out_chan.
// Throughput: one transaction per cycle; every stage takes an item each cycle unless back-pressure stalls it.
// A write is visible to an event accepted in the very next cycle.
// Reset: the pipeline empties and every table entry reads as the full range
// 0..127 at once; no clearing pass is needed.
// Stall: when out_chan.ready is low the result holds, and in_chan keeps accepting
// until the bubbles in the five stages are filled, then ready drops.
// Depends on rmap_pkg, rmap_in_if, rmap_out_if, rmap_lookup, rmap_minmax,
// rmap_remstep and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module midi_controller_range_remap #(
  parameter int NUM_CONTROLLERS = rmap_pkg::NUM_CONTROLLERS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rmap_in_if.sink    in_chan,
  rmap_out_if.source out_chan
);

`include "assert_macros.svh"

  logic              s1_valid, s1_ready;
  rmap_pkg::stage_t  s1_data;
  logic              s2_valid, s2_ready;
  rmap_pkg::stage_t  s2_data;
  logic              s3_valid, s3_ready;
  rmap_pkg::stage_t  s3_data;
  logic              s4_valid, s4_ready;
  rmap_pkg::stage_t  s4_data;

  logic                          out_v_r;
  logic [rmap_pkg::VAL_W-1:0]    cc_out_r;
  logic [rmap_pkg::VAL_W-1:0]    val_out_r;
  logic [rmap_pkg::VAL_W-1:0]    val_out_nxt;
  logic [rmap_pkg::SPAN_W-1:0]   sum;
  logic                          wr_acc;
  logic                          ev_acc;

  rmap_lookup #(
    .NUM_CONTROLLERS (NUM_CONTROLLERS)
  ) u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  rmap_minmax u_minmax (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  rmap_remstep #(
    .TOP_BIT   (rmap_pkg::REM_HI_TOP),
    .NUM_STEPS (rmap_pkg::REM_HI_STEPS)
  ) u_rem_hi (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  rmap_remstep #(
    .TOP_BIT   (rmap_pkg::REM_LO_TOP),
    .NUM_STEPS (rmap_pkg::REM_LO_STEPS)
  ) u_rem_lo (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (s4_valid),
    .dn_ready (s4_ready),
    .dn_data  (s4_data)
  );

  assign s4_ready = !out_v_r || out_chan.ready;

  // min + rem never exceeds max, the clamp only guards the 7-bit range
  always_comb begin
    sum = {1'b0, s4_data.mn} + s4_data.rem;
    if (s4_data.pass) begin
      val_out_nxt = s4_data.value;
    end else if (s4_data.eq) begin
      val_out_nxt = s4_data.lo;
    end else if (sum > {1'b0, rmap_pkg::VALUE_MAX}) begin
      val_out_nxt = rmap_pkg::VALUE_MAX;
    end else begin
      val_out_nxt = sum[rmap_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      cc_out_r  <= s4_data.cc;
      val_out_r <= val_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s4_ready) begin
      out_v_r <= s4_valid;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.controller_out = cc_out_r;
  assign out_chan.remapped_value = val_out_r;

  assign wr_acc = in_chan.valid && in_chan.ready && in_chan.opcode == rmap_pkg::OP_WRITE;
  assign ev_acc = in_chan.valid && in_chan.ready && in_chan.opcode == rmap_pkg::OP_EVENT;

  `RMAP_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_v_r, in_chan.ready, "input stalled")
  `RMAP_ASSERT_NXT(a_write_no_item, clk, rst_n, wr_acc, !s1_valid, "write entered pipeline")
  `RMAP_ASSERT_NXT(a_event_enters, clk, rst_n, ev_acc, s1_valid, "event lost at lookup")

endmodule

`default_nettype wire

### bench/midi_controller_range_remap_test.sv
// self-checking bench for midi_controller_range_remap: directed table, then random traffic
// predicts each remapped control change from its own bound tables and checks on out_chan
// depends on rmap_pkg, rmap_in_if, rmap_out_if and the remap rtl
`timescale 1ns / 1ps

module midi_controller_range_remap_test;

  localparam int NUM_CTRL      = rmap_pkg::NUM_CONTROLLERS_DEF;
  localparam int VAL_W         = rmap_pkg::VAL_W;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int DRAIN_CYCLES  = 5000;
  localparam int TAIL_CYCLES   = 20;
  localparam int DIR_ROWS      = 25;
  localparam int PEND_DEPTH    = 16;

  typedef struct packed {
    logic             op;
    logic [VAL_W-1:0] cc;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
  } remap_txn_t;

  typedef struct packed {
    logic [VAL_W-1:0] cc;
    logic [VAL_W-1:0] value;
  } remap_result_t;

  // fixed marks rows whose result is typed in; other event rows use the predictor
  typedef struct packed {
    remap_txn_t       txn;
    logic             fixed;
    logic [VAL_W-1:0] want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  rmap_in_if  in_chan();
  rmap_out_if out_chan();

  midi_controller_range_remap #(
    .NUM_CONTROLLERS(NUM_CTRL)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  logic [VAL_W-1:0] bound_lo [NUM_CTRL];
  logic [VAL_W-1:0] bound_hi [NUM_CTRL];
  remap_result_t    pend_mem [PEND_DEPTH];
  int               pend_head;
  int               pend_tail;
  int               pend_count;
  int               mismatch_count;
  bit               idle_on;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // reset range passes through
    '{'{rmap_pkg::OP_EVENT, 7'd0,   7'd0,   7'd0,   7'd0  }, 1'b1, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd127, 7'd127, 7'd0,   7'd0  }, 1'b1, 7'd127},
    '{'{rmap_pkg::OP_EVENT, 7'd85,  7'd42,  7'd127, 7'd127}, 1'b1, 7'd42 },
    '{'{rmap_pkg::OP_WRITE, 7'd5,   7'd0,   7'd20,  7'd20 }, 1'b0, 7'd0  },
    // equal bounds give the bound
    '{'{rmap_pkg::OP_EVENT, 7'd5,   7'd127, 7'd0,   7'd0  }, 1'b1, 7'd20 },
    '{'{rmap_pkg::OP_WRITE, 7'd6,   7'd0,   7'd0,   7'd0  }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd6,   7'd99,  7'd0,   7'd0  }, 1'b1, 7'd0  },
    '{'{rmap_pkg::OP_WRITE, 7'd7,   7'd0,   7'd127, 7'd127}, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd7,   7'd0,   7'd0,   7'd0  }, 1'b1, 7'd127},
    '{'{rmap_pkg::OP_WRITE, 7'd8,   7'd0,   7'd10,  7'd19 }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd8,   7'd127, 7'd0,   7'd0  }, 1'b0, 7'd0  },
    // reversed bounds and two-value ranges
    '{'{rmap_pkg::OP_WRITE, 7'd9,   7'd0,   7'd19,  7'd10 }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd9,   7'd55,  7'd0,   7'd0  }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_WRITE, 7'd10,  7'd0,   7'd0,   7'd1  }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd10,  7'd127, 7'd0,   7'd0  }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_WRITE, 7'd127, 7'd85,  7'd126, 7'd127}, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd127, 7'd126, 7'd0,   7'd0  }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd127, 7'd127, 7'd0,   7'd0  }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_WRITE, 7'd0,   7'd0,   7'd127, 7'd0  }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd0,   7'd85,  7'd0,   7'd0  }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_WRITE, 7'd42,  7'd0,   7'd85,  7'd42 }, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd42,  7'd127, 7'd42,  7'd85 }, 1'b0, 7'd0  },
    // untouched entry, then a rewritten one
    '{'{rmap_pkg::OP_EVENT, 7'd1,   7'd127, 7'd0,   7'd0  }, 1'b1, 7'd127},
    '{'{rmap_pkg::OP_WRITE, 7'd8,   7'd0,   7'd0,   7'd127}, 1'b0, 7'd0  },
    '{'{rmap_pkg::OP_EVENT, 7'd8,   7'd100, 7'd0,   7'd0  }, 1'b1, 7'd100}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // expected results wait here in order of acceptance
  task automatic pend_put(input remap_result_t res);
    if (pend_count == PEND_DEPTH) begin
      report_mismatch("expected result fifo overflow");
    end else begin
      pend_mem[pend_tail] = res;
      pend_tail = (pend_tail + 1) % PEND_DEPTH;
      pend_count++;
    end
  endtask

  function automatic remap_result_t pend_take();
    remap_result_t res;
    res = pend_mem[pend_head];
    pend_head = (pend_head + 1) % PEND_DEPTH;
    pend_count--;
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] remap_ctrl(input logic [VAL_W-1:0] cc,
                                                  input logic [VAL_W-1:0] value);
    int lo;
    int hi;
    int mn;
    int mx;
    int nv;
    if (int'(cc) >= NUM_CTRL) return value;
    lo = int'(bound_lo[cc]);
    hi = int'(bound_hi[cc]);
    if (lo == hi) return bound_lo[cc];
    mn = (lo <= hi) ? lo : hi;
    mx = (lo <= hi) ? hi : lo;
    nv = mn + (int'(value) % (mx - mn + 1));
    if (nv > int'(rmap_pkg::VALUE_MAX)) nv = int'(rmap_pkg::VALUE_MAX);
    return nv[VAL_W-1:0];
  endfunction

  // table write or expected result for one accepted transaction
  task automatic track_transaction(input remap_txn_t txn);
    if (txn.op == rmap_pkg::OP_WRITE) begin
      if (int'(txn.cc) < NUM_CTRL) begin
        bound_lo[txn.cc] = txn.lo;
        bound_hi[txn.cc] = txn.hi;
      end
    end else begin
      pend_put('{cc: txn.cc, value: remap_ctrl(txn.cc, txn.value)});
    end
  endtask

  function automatic remap_txn_t draw_transaction();
    remap_txn_t txn;
    int         pick;
    txn.op    = ($urandom_range(0, 3) == 0) ? rmap_pkg::OP_WRITE : rmap_pkg::OP_EVENT;
    txn.value = 7'($urandom_range(0, 127));
    txn.lo    = 7'($urandom_range(0, 127));
    txn.hi    = 7'($urandom_range(0, 127));
    // most traffic lands on a few controllers so writes are followed by events
    pick = int'($urandom_range(0, 9));
    if (pick < 5)       txn.cc = 7'($urandom_range(0, 7));
    else if (pick == 5) txn.cc = 7'd0;
    else if (pick == 6) txn.cc = 7'd127;
    else                txn.cc = 7'($urandom_range(0, 127));
    if (txn.op == rmap_pkg::OP_WRITE) begin
      pick = int'($urandom_range(0, 9));
      if (pick == 0) txn.hi = txn.lo;
      else if (pick == 1) begin
        txn.lo = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'd127;
        txn.hi = ~txn.lo;
      end else if (pick < 5) begin
        txn.hi = (int'(txn.lo) > 120) ? txn.lo - 7'($urandom_range(1, 6))
                                      : txn.lo + 7'($urandom_range(1, 6));
      end
    end
    return txn;
  endfunction

  // called just after a rising edge; returns at the edge that takes the transaction
  task automatic send_transaction(input remap_txn_t txn);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 19)) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid             <= 1'b1;
    in_chan.opcode            <= txn.op;
    in_chan.controller_number <= txn.cc;
    in_chan.control_value     <= txn.value;
    in_chan.entry_low         <= txn.lo;
    in_chan.entry_high        <= txn.hi;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pend_count != 0) @(posedge clk);
  endtask

  // result side: random stalls per transaction while idle_on is set
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? int'($urandom_range(0, 19)) : 0;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    remap_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pend_count == 0) begin
        report_mismatch($sformatf("unexpected result cc=%0d value=%0d",
                                  out_chan.controller_out, out_chan.remapped_value));
      end else begin
        want = pend_take();
        if (out_chan.controller_out !== want.cc)
          report_mismatch($sformatf("controller_out %0d, expected %0d",
                                    out_chan.controller_out, want.cc));
        if (out_chan.remapped_value !== want.value)
          report_mismatch($sformatf("remapped_value %0d, expected %0d (cc %0d)",
                                    out_chan.remapped_value, want.value, want.cc));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    remap_txn_t txn;
    int         waited;
    mismatch_count = 0;
    pend_head      = 0;
    pend_tail      = 0;
    pend_count     = 0;
    idle_on        = 1'b0;
    for (int k = 0; k < NUM_CTRL; k++) begin
      bound_lo[k] = 7'd0;
      bound_hi[k] = rmap_pkg::VALUE_MAX;
    end
    rst_n                     <= 1'b0;
    in_chan.valid             <= 1'b0;
    in_chan.opcode            <= rmap_pkg::OP_EVENT;
    in_chan.controller_number <= '0;
    in_chan.control_value     <= '0;
    in_chan.entry_low         <= '0;
    in_chan.entry_high        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows back to back, so a write is followed at once by its event
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_transaction(dir_rows[r].txn);
      if (dir_rows[r].fixed) begin
        // fixed rows are all events, so the tables stay as they are
        pend_put('{cc: dir_rows[r].txn.cc, value: dir_rows[r].want});
      end else begin
        track_transaction(dir_rows[r].txn);
      end
    end
    hold_until_drained();

    idle_on = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      txn = draw_transaction();
      send_transaction(txn);
      track_transaction(txn);
    end
    in_chan.valid <= 1'b0;

    waited = 0;
    while (pend_count != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pend_count != 0)
      report_mismatch($sformatf("%0d results never arrived", pend_count));

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
